### sv/psh_pkg.sv
// constants and widths shared by the polynomial string hash modules
// no dependencies

package psh_pkg;

  localparam int CharW  = 8;
  localparam int PowerW = 30;
  localparam int SumW   = 20;
  localparam int CountW = 21;
  localparam int MultW  = 9;
  localparam int DivW   = 31;
  localparam int AccW   = 32;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam int MulCntW = $clog2(MultW);
  localparam int DivCntW = $clog2(DivW);

  localparam logic [PowerW-1:0] HashPrime  = 30'd1000000007;
  localparam logic [AccW-1:0]   HashPrime1 = 32'd1000000007;
  localparam logic [AccW-1:0]   HashPrime2 = 32'd2000000014;
  localparam logic [MultW-1:0]  HashBase   = 9'd263;

  localparam logic [CountW-1:0] BucketMax   = 21'd1048576;
  localparam logic [CountW-1:0] BucketMin   = 21'd1;
  localparam logic [CountW-1:0] BucketReset = 21'd1024;

  localparam logic [PowerW-1:0] PowerReset = 30'd1;

  // register index, taken from the word address bit
  localparam logic RegBucketCount = 1'b0;

endpackage

### sv/psh_mulmod.sv
// bit-serial modular multiplier: result = addend * mult mod 1000000007
// one multiplier bit per cycle, msb first; uses psh_pkg

module psh_mulmod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [psh_pkg::PowerW-1:0] addend,
  input  logic [psh_pkg::MultW-1:0]  mult,
  output logic                       done,
  output logic [psh_pkg::PowerW-1:0] result
);
  import psh_pkg::*;

  logic [PowerW-1:0]  acc_r, acc_nxt;
  logic [PowerW-1:0]  addend_r;
  logic [MultW-1:0]   mult_r;
  logic [MulCntW-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [AccW-1:0]    sum_w;
  logic [AccW-1:0]    red_w;

  always_comb begin
    sum_w = {1'b0, acc_r, 1'b0} + (mult_r[MultW-1] ? {2'b00, addend_r} : {AccW{1'b0}});
    if (sum_w >= HashPrime2) begin
      red_w = sum_w - HashPrime2;
    end else if (sum_w >= HashPrime1) begin
      red_w = sum_w - HashPrime1;
    end else begin
      red_w = sum_w;
    end
    acc_nxt = red_w[PowerW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MulCntW'(MultW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      addend_r <= addend;
      mult_r   <= mult;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      mult_r <= {mult_r[MultW-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### sv/psh_remu.sv
// bit-serial restoring remainder unit: result = dividend mod divisor
// one dividend bit per cycle, msb first; uses psh_pkg

module psh_remu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [psh_pkg::DivW-1:0]   dividend,
  input  logic [psh_pkg::CountW-1:0] divisor,
  output logic                       done,
  output logic [psh_pkg::SumW-1:0]   result
);
  import psh_pkg::*;

  logic [DivW-1:0]    quo_r;
  logic [CountW-1:0]  rem_r, rem_nxt;
  logic [CountW-1:0]  div_r;
  logic [DivCntW-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [CountW:0]    trial_w;

  always_comb begin
    trial_w = {rem_r, quo_r[DivW-1]};
    if (trial_w >= {1'b0, div_r}) begin
      trial_w = trial_w - {1'b0, div_r};
    end
    rem_nxt = trial_w[CountW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DivW-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = rem_r[SumW-1:0];

endmodule

### sv/polynomial_string_hash.sv
// Polynomial string hash: one character item per string position, bucket index
// out on the flagged last character. Each item passes through the two bit-serial
// modular multipliers (term and next power, side by side), then the bit-serial
// remainder unit that folds the running sum and the term modulo the bucket count;
// a new item is taken only once the last is through. The result sits in an output
// register, so the next string can start while the bucket index waits.
// Uses psh_pkg, psh_mulmod and psh_remu.

module polynomial_string_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [psh_pkg::CharW-1:0]  in_char_code,
  input  logic                       in_last_char,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [psh_pkg::SumW-1:0]   out_bucket_index,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [psh_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [psh_pkg::DataW-1:0]  cfg_pwdata,
  output logic [psh_pkg::DataW-1:0]  cfg_prdata,
  output logic                       cfg_pready
);
  import psh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_REM  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CountW-1:0] bucket_count_r, bucket_count_nxt;
  logic [PowerW-1:0] power_r, power_nxt;
  logic [SumW-1:0]   sum_r, sum_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SumW-1:0]   out_index_r, out_index_nxt;

  logic              in_accept;
  logic              cfg_write;
  logic [CountW-1:0] wdata_w;
  logic              term_done, pow_done, mul_done;
  logic [PowerW-1:0] term_res, pow_res;
  logic              rem_start, rem_done;
  logic [SumW-1:0]   rem_res;
  logic [DivW-1:0]   dividend_w;
  logic              slot_free;

  assign in_accept = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign mul_done  = term_done && pow_done;
  assign slot_free = !out_valid_r || out_ready;
  assign dividend_w = {{(DivW-SumW){1'b0}}, sum_r} + {{(DivW-PowerW){1'b0}}, term_res};

  psh_mulmod u_term (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .addend (power_r),
    .mult   ({1'b0, in_char_code}),
    .done   (term_done),
    .result (term_res)
  );

  psh_mulmod u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .addend (power_r),
    .mult   (HashBase),
    .done   (pow_done),
    .result (pow_res)
  );

  psh_remu u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (dividend_w),
    .divisor  (bucket_count_r),
    .done     (rem_done),
    .result   (rem_res)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == RegBucketCount);
  assign cfg_prdata = (cfg_paddr[2] == RegBucketCount) ?
                      {{(DataW-CountW){1'b0}}, bucket_count_r} : {DataW{1'b0}};

  always_comb begin
    wdata_w = cfg_pwdata[CountW-1:0];
    if (wdata_w == '0) begin
      wdata_w = BucketMin;
    end else if (wdata_w > BucketMax) begin
      wdata_w = BucketMax;
    end
    bucket_count_nxt = cfg_write ? wdata_w : bucket_count_r;
  end

  always_comb begin
    state_nxt     = state_r;
    power_nxt     = power_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    rem_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          last_nxt  = in_last_char;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          power_nxt = pow_res;
          rem_start = 1'b1;
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (rem_done) begin
          if (last_r) begin
            power_nxt = PowerReset;
            sum_nxt   = '0;
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_index_nxt = rem_res;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            sum_nxt   = rem_res;
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = rem_res;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      bucket_count_r <= BucketReset;
      power_r        <= PowerReset;
      sum_r          <= '0;
      last_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      bucket_count_r <= bucket_count_nxt;
      power_r        <= power_nxt;
      sum_r          <= sum_nxt;
      last_r         <= last_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r <= out_index_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_index_r;

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    power_r < HashPrime)
    else $error("running power out of range");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier done outside multiply phase");

  a_rem_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> state_r == S_REM)
    else $error("remainder done outside remainder phase");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_REM || $past(state_r) == S_OUT))
    else $error("result item without finished string");

endmodule

### sim/tb.sv
// testbench for polynomial_string_hash: random strings, bucket count changes, stalls
// predicts each bucket index and checks every result item in order
// depends on psh_pkg and polynomial_string_hash

module tb;
  import psh_pkg::*;

  localparam longint unsigned HashModulus    = 64'd1000000007;
  localparam longint unsigned HashMultiplier = 64'd263;
  localparam longint unsigned BucketCeiling  = 64'd1048576;
  localparam logic [CountW-1:0] BucketDefault = 21'd1024;
  localparam logic [AddrW-1:0] BucketCountAddr = {RegBucketCount, 2'b00};
  localparam int SettleCycles = 60;
  localparam int IdleLimit    = 4000;
  localparam int PhaseChars   = 250;
  localparam int RandomPhases = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CharW-1:0]  in_char_code;
  logic              in_last_char;
  logic              out_valid;
  logic              out_ready;
  logic [SumW-1:0]   out_bucket_index;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [AddrW-1:0]  cfg_paddr;
  logic [DataW-1:0]  cfg_pwdata;
  logic [DataW-1:0]  cfg_prdata;
  logic              cfg_pready;

  // hash state as the block should hold it
  logic [PowerW-1:0] hash_power;
  logic [SumW-1:0]   hash_sum;
  logic [CountW-1:0] bucket_m;
  logic [SumW-1:0]   expected_buckets[$];
  logic [SumW-1:0]   wanted_bucket;

  int mismatches     = 0;
  int strings_hashed = 0;
  int chars_sent     = 0;
  int bucket_writes  = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  int stall_mode     = 0;
  int stall_left     = 0;

  polynomial_string_hash dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [CountW-1:0] stored_bucket_count(input logic [DataW-1:0] value);
    logic [CountW-1:0] v;
    v = value[CountW-1:0];
    if (v == '0) begin
      v = 21'd1;
    end else if (v > BucketCeiling) begin
      v = CountW'(BucketCeiling);
    end
    return v;
  endfunction

  task automatic hash_char(input logic [CharW-1:0] code, input logic last);
    longint unsigned p;
    longint unsigned term;
    longint unsigned sum;
    p = hash_power;
    term = (p * code) % HashModulus;
    term = term % bucket_m;
    sum = (hash_sum + term) % bucket_m;
    hash_sum = SumW'(sum);
    hash_power = PowerW'((p * HashMultiplier) % HashModulus);
    if (last) begin
      expected_buckets.push_back(SumW'(sum));
      hash_power = 30'd1;
      hash_sum = '0;
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] code, input logic last);
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= code;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hash_char(code, last);
    chars_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_buckets.size() != 0) @(posedge clk);
  endtask

  // idle the block fully before touching the register
  task automatic drain_results();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic program_bucket_count(input logic [DataW-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= BucketCountAddr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    bucket_m = stored_bucket_count(value);
    bucket_writes++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== DataW'(bucket_m)) begin
      report_mismatch("bucket_count readback", cfg_prdata, DataW'(bucket_m));
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [CharW-1:0] random_code();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return CharW'($urandom_range(0, 255));
  endfunction

  function automatic logic [DataW-1:0] random_bucket_value();
    case ($urandom_range(0, 5))
      0: return DataW'($urandom_range(1, 16));
      1: return DataW'(1) << $urandom_range(0, 20);
      2: return DataW'($urandom_range(1048000, 1048576));
      3: return DataW'($urandom_range(1, 1048576));
      4: return DataW'($urandom());
      default: return DataW'($urandom_range(1048577, 2097151));
    endcase
  endfunction

  task automatic paced_send(input logic [CharW-1:0] code, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 50));
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_char(code, last);
  endtask

  task automatic test_default_buckets();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    repeat (4) send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_bucket_limits();
    logic [DataW-1:0] limits[5];
    limits = '{32'h0000_0000, 32'h0010_0000, 32'h001F_FFFF, 32'hFFE0_0000, 32'h000F_FFFF};
    foreach (limits[i]) begin
      drain_results();
      program_bucket_count(limits[i]);
      send_char(random_code(), 1'b0);
      send_char(8'hFF, 1'b1);
    end
  endtask

  task automatic test_midstring_bucket_change();
    drain_results();
    program_bucket_count(32'd1000);
    send_char(8'd97, 1'b0);
    send_char(8'd98, 1'b0);
    drain_results();
    program_bucket_count(32'd7);
    send_char(8'd99, 1'b0);
    send_char(8'd100, 1'b1);
  endtask

  task automatic test_random_strings();
    int sent;
    int len;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain_results();
      program_bucket_count(random_bucket_value());
      sent = 0;
      while (sent < PhaseChars) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          paced_send(random_code(), i == len - 1);
        end
        sent += len;
        if ($urandom_range(0, 39) == 0) begin
          wait_for_results();
        end
      end
      // leave a string open across the next bucket count write
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 5)) paced_send(random_code(), 1'b0);
      end
    end
    paced_send(random_code(), 1'b1);
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_left % 64 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_buckets.size() == 0) begin
        report_mismatch("unexpected bucket_index", DataW'(out_bucket_index), '0);
      end else begin
        wanted_bucket = expected_buckets.pop_front();
        if (out_bucket_index !== wanted_bucket) begin
          report_mismatch("bucket_index", DataW'(out_bucket_index), DataW'(wanted_bucket));
        end
        strings_hashed++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = '0;
    in_last_char = 1'b0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hash_power = 30'd1;
    hash_sum = '0;
    bucket_m = BucketDefault;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_buckets();
    test_bucket_limits();
    test_midstring_bucket_change();
    test_random_strings();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    $display("hashed %0d strings from %0d characters under %0d bucket count writes",
             strings_hashed, chars_sent, bucket_writes);
    $display("covered zero, exact and oversized bucket counts and mid-string changes");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
